/* src/multipart_boundary_scanner_core_defines.svh */
// Assertion macros for the multipart boundary scanner.
`ifndef MULTIPART_BOUNDARY_SCANNER_CORE_DEFINES_SVH
`define MULTIPART_BOUNDARY_SCANNER_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk, off while in reset.
`define MBS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbs assertion failed");
// Next-cycle implication, sampled on clk, off while in reset.
`define MBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbs assertion failed");
`else
`define MBS_ASSERT_NOW(label, ante, cons)
`define MBS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* src/mbs_pkg.sv */
// Constants and types shared by the multipart boundary scanner.
`default_nettype none

package mbs_pkg;

  localparam int MAX_BOUNDARY = 56;
  localparam int LEN_W        = 6;
  localparam int NUM_WORDS    = 7;
  localparam int WORD_W       = 64;
  localparam int IDX_W        = 3;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_DASH = 8'h2D;

  localparam logic [IDX_W-1:0] REG_LENGTH = 3'd0;
  localparam logic [IDX_W-1:0] REG_TEXT_A = 3'd1;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_BOUNDARY = 2'd1,
    EV_LAST     = 2'd2,
    EV_ERROR    = 2'd3
  } event_t;

endpackage

`default_nettype wire

/* src/multipart_boundary_scanner_core.sv */
// Multipart body scanner: one byte per transfer, reports boundary delimiters.
// A byte's result is registered when the byte is accepted.
// Throughput: one byte per cycle; the next byte is taken while a result waits
// as long as the output register is being drained in the same cycle.
// Reset (synchronous, rst_n low): matcher at start, nothing held, boundary length 1,
// boundary text all zero, no result pending.
`default_nettype none
`include "multipart_boundary_scanner_core_defines.svh"

module multipart_boundary_scanner_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                in_body_byte,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output mbs_pkg::event_t                out_event_res,
  output logic [mbs_pkg::LEN_W-1:0]      out_pending_count,
  input  wire logic                      cfg_we,
  input  wire logic [mbs_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [mbs_pkg::WORD_W-1:0] cfg_data
);
  import mbs_pkg::*;

  typedef enum logic [2:0] {
    ST_START     = 3'd0,
    ST_CR        = 3'd1,
    ST_LF        = 3'd2,
    ST_DASH1     = 3'd3,
    ST_TEXT      = 3'd4,
    ST_TEXT_DONE = 3'd5,
    ST_END_CR    = 3'd6,
    ST_END_DASH1 = 3'd7
  } phase_t;

  // configuration
  logic [LEN_W-1:0]  len_r;
  logic [WORD_W-1:0] words_r [NUM_WORDS];

  // matcher state and result register
  phase_t            phase_r, phase_nxt;
  logic [LEN_W-1:0]  text_idx_r, text_idx_nxt;
  logic [LEN_W-1:0]  held_r, held_nxt;
  logic              out_valid_r;
  event_t            out_event_r, event_nxt;
  logic [LEN_W-1:0]  out_count_r, count_nxt;

  logic              accept;
  logic [LEN_W-1:0]  used_len;
  logic [WORD_W-1:0] sel_word;
  logic [7:0]        text_byte;
  logic              text_hit;
  logic [LEN_W-1:0]  text_idx_inc;
  logic              is_cr;

  assign in_ready          = !out_valid_r || out_ready;
  assign accept            = in_valid && in_ready;
  assign out_valid         = out_valid_r;
  assign out_event_res     = out_event_r;
  assign out_pending_count = out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_W'(1);
      for (int i = 0; i < NUM_WORDS; i++) begin
        words_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LENGTH: len_r <= cfg_data[LEN_W-1:0];
        default:    words_r[cfg_index - REG_TEXT_A] <= cfg_data;
      endcase
    end
  end

  // clamp length to 1..MAX_BOUNDARY
  always_comb begin
    if (len_r == '0) begin
      used_len = LEN_W'(1);
    end else if (len_r > LEN_W'(MAX_BOUNDARY)) begin
      used_len = LEN_W'(MAX_BOUNDARY);
    end else begin
      used_len = len_r;
    end
  end

  // pick the boundary byte at the current text position
  always_comb begin
    sel_word = '0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (text_idx_r[LEN_W-1:3] == IDX_W'(w)) begin
        sel_word = words_r[w];
      end
    end
  end

  assign text_byte    = sel_word[{text_idx_r[2:0], 3'b000} +: 8];
  assign text_hit     = (text_idx_r < used_len) && (in_body_byte == text_byte);
  assign text_idx_inc = text_idx_r + LEN_W'(1);
  assign is_cr        = (in_body_byte == CH_CR);

  always_comb begin
    phase_nxt    = phase_r;
    text_idx_nxt = text_idx_r;
    held_nxt     = held_r;
    event_nxt    = EV_NONE;
    count_nxt    = '0;

    unique case (phase_r)
      ST_START: begin
        phase_nxt    = is_cr ? ST_CR : ST_START;
        text_idx_nxt = '0;
        held_nxt     = is_cr ? LEN_W'(1) : '0;
      end
      ST_CR, ST_LF, ST_DASH1: begin
        if ((phase_r == ST_CR && in_body_byte == CH_LF) ||
            (phase_r != ST_CR && in_body_byte == CH_DASH)) begin
          phase_nxt    = (phase_r == ST_CR) ? ST_LF :
                         (phase_r == ST_LF) ? ST_DASH1 : ST_TEXT;
          text_idx_nxt = '0;
          held_nxt     = held_r + LEN_W'(1);
        end else begin
          phase_nxt    = is_cr ? ST_CR : ST_START;
          text_idx_nxt = '0;
          held_nxt     = is_cr ? LEN_W'(1) : '0;
        end
      end
      ST_TEXT: begin
        if (text_hit) begin
          text_idx_nxt = text_idx_inc;
          held_nxt     = held_r + LEN_W'(1);
          if (text_idx_inc >= used_len) begin
            phase_nxt = ST_TEXT_DONE;
          end
        end else begin
          phase_nxt    = is_cr ? ST_CR : ST_START;
          text_idx_nxt = '0;
          held_nxt     = is_cr ? LEN_W'(1) : '0;
        end
      end
      ST_TEXT_DONE: begin
        if (is_cr) begin
          phase_nxt = ST_END_CR;
          held_nxt  = held_r + LEN_W'(1);
        end else if (in_body_byte == CH_DASH) begin
          phase_nxt = ST_END_DASH1;
          held_nxt  = held_r + LEN_W'(1);
        end else begin
          event_nxt    = EV_ERROR;
          phase_nxt    = ST_START;
          text_idx_nxt = '0;
          held_nxt     = '0;
        end
      end
      ST_END_CR, ST_END_DASH1: begin
        // closing byte decides the event; always drop back to start
        if (phase_r == ST_END_CR && in_body_byte == CH_LF) begin
          event_nxt = EV_BOUNDARY;
          count_nxt = held_r + LEN_W'(1);
        end else if (phase_r == ST_END_DASH1 && in_body_byte == CH_DASH) begin
          event_nxt = EV_LAST;
          count_nxt = held_r + LEN_W'(1);
        end else begin
          event_nxt = EV_ERROR;
        end
        phase_nxt    = ST_START;
        text_idx_nxt = '0;
        held_nxt     = '0;
      end
      default: begin
        phase_nxt    = ST_START;
        text_idx_nxt = '0;
        held_nxt     = '0;
      end
    endcase

    if (event_nxt == EV_NONE) begin
      count_nxt = held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ST_START;
      text_idx_r  <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        text_idx_r  <= text_idx_nxt;
        held_r      <= held_nxt;
        out_valid_r <= 1'b1;
        out_event_r <= event_nxt;
        out_count_r <= count_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `MBS_ASSERT_NOW(a_start_holds_nothing, phase_r == ST_START, held_r == '0)
  `MBS_ASSERT_NOW(a_text_held_tracks_index, phase_r == ST_TEXT,
                  held_r == text_idx_r + LEN_W'(4))
  `MBS_ASSERT_NEXT(a_event_restarts, accept,
                   out_event_r == EV_NONE || (phase_r == ST_START && held_r == '0))

endmodule

`default_nettype wire
